### hw/rtl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// shared constants, types and controller states of the nearest neighbour core
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int MaxSubjects   = 64;
  localparam int MaxFeatures   = 64;
  localparam int MaxNeighbours = 16;
  localparam int SubjW  = $clog2(MaxSubjects);
  localparam int FeatW  = $clog2(MaxFeatures);
  localparam int AddrW  = SubjW + FeatW;
  localparam int CntW   = 7;
  localparam int KW     = 5;
  localparam int DistW  = 20;
  localparam int SqW    = 32;
  localparam int SumW   = 40;
  localparam int RootW  = 20;
  localparam logic [DistW-1:0] DistMax = 20'hFFFFF;

  localparam logic [1:0] CfgNumSubjects = 2'd0;
  localparam logic [1:0] CfgNumFeatures = 2'd1;
  localparam logic [1:0] CfgCutoff      = 2'd2;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC,
    ST_ACC_END,
    ST_SQRT,
    ST_SQRT_END,
    ST_SEL,
    ST_SEL_END,
    ST_OUT
  } knn_state_t;

  // controller to datapath
  typedef struct packed {
    logic start;        // latch query, clear marks, subject counter 0
    logic feat_clr;     // clear sum and feature counter
    logic acc_rd;       // issue reads for next feature
    logic acc_add;      // add product of registered reads
    logic sqrt_init;    // load root unit
    logic sqrt_step;    // one root step
    logic dist_wr;      // store distance of current subject
    logic subj_inc;     // next subject
    logic sel_clr;      // begin a selection pass
    logic sel_step;     // test one candidate
    logic sel_done;     // result taken, mark pick
    logic res_taken;    // result delivered
  } knn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic feat_last;
    logic subj_last;
    logic sqrt_last;
    logic res_last;
  } knn_stat_t;

endpackage

### hw/rtl/k_nearest_neighbour_search_core.sv
// ----------------------------------------------------------------------------
// k_nearest_neighbour_search_core
// brute force k nearest neighbour search over a signed Q8.8 feature store
// ----------------------------------------------------------------------------
// Load requests (kind 0) write one feature value and are taken one per cycle.
// A query request (kind 1) stalls the input until its last result is taken.
// The query runs a distance pass (one store read pair per feature plus a
// 20-step root unit per subject), then one selection scan over the subjects
// per result.
module k_nearest_neighbour_search_core import knn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // subject, feature, value, neighbour_count, zero pad
  input  logic        in_tuser,  // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // neighbour, distance, found, zero pad
  output logic        out_tlast
);

  logic [CntW-1:0]  num_subjects_r;
  logic [CntW-1:0]  num_features_r;
  logic [DistW-1:0] cutoff_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_subjects_r <= CntW'(64);
      num_features_r <= CntW'(64);
      cutoff_r       <= DistMax;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgNumSubjects: num_subjects_r <= cfg_wdata[CntW-1:0];
        CfgNumFeatures: num_features_r <= cfg_wdata[CntW-1:0];
        CfgCutoff:      cutoff_r       <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  knn_cmd_t  cmd;
  knn_stat_t stat;
  logic busy, res_valid, in_fire, out_fire, query_go, load_we;
  logic [SubjW-1:0] res_neighbour;
  logic [DistW-1:0] res_distance;
  logic res_found, res_last;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign query_go  = in_fire && (in_tuser == KindQuery) && (in_tdata[32:28] != '0);
  assign load_we   = in_fire && (in_tuser == KindLoad);
  assign out_fire  = out_tvalid && out_tready;

  knn_ctrl u_ctrl (
    .clk, .rst_n, .query_go, .out_fire, .stat, .cmd, .busy, .res_valid
  );

  knn_datapath u_dp (
    .clk, .rst_n, .load_we,
    .in_subject(in_tdata[5:0]), .in_feature(in_tdata[11:6]),
    .in_value(in_tdata[27:12]), .in_count(in_tdata[32:28]),
    .num_subjects(num_subjects_r), .num_features(num_features_r),
    .cutoff(cutoff_r), .cmd, .stat,
    .res_neighbour, .res_distance, .res_found, .res_last
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {5'd0, res_found, res_distance, res_neighbour};
  assign out_tlast  = res_last;

  // input is held off while a result is offered
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input open during result");
  // the last result returns the core to idle
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_tlast) |=> in_tready) else $error("query did not end");
  // no result while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("result while idle");

endmodule

### hw/rtl/knn_ctrl.sv
// ----------------------------------------------------------------------------
// knn_ctrl
// query sequencer: distance pass, root unit, then one selection pass per result
// ----------------------------------------------------------------------------
module knn_ctrl import knn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      query_go,
  input  logic      out_fire,
  input  knn_stat_t stat,
  output knn_cmd_t  cmd,
  output logic      busy,
  output logic      res_valid
);

  knn_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (query_go) state_nxt = ST_ACC_RD;
      ST_ACC_RD:   state_nxt = ST_ACC;
      ST_ACC:      if (stat.feat_last) state_nxt = ST_ACC_END;
      ST_ACC_END:  state_nxt = ST_SQRT;
      ST_SQRT:     if (stat.sqrt_last) state_nxt = ST_SQRT_END;
      ST_SQRT_END: state_nxt = stat.subj_last ? ST_SEL : ST_ACC_RD;
      ST_SEL:      if (stat.subj_last) state_nxt = ST_SEL_END;
      ST_SEL_END:  state_nxt = ST_OUT;
      ST_OUT:      if (out_fire) state_nxt = stat.res_last ? ST_IDLE : ST_SEL;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.start    = query_go;
        cmd.feat_clr = query_go;
      end
      ST_ACC_RD: cmd.acc_rd = 1'b1;
      ST_ACC: begin
        cmd.acc_rd  = 1'b1;
        cmd.acc_add = 1'b1;
      end
      ST_ACC_END: begin
        cmd.acc_add   = 1'b1;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
      end
      ST_SQRT_END: begin
        cmd.dist_wr  = 1'b1;
        cmd.subj_inc = 1'b1;
        cmd.feat_clr = 1'b1;
        cmd.sel_clr  = stat.subj_last;
      end
      ST_SEL: begin
        cmd.sel_step = 1'b1;
        cmd.subj_inc = 1'b1;
      end
      // mark the pick once the last compare has settled and the result is taken
      ST_OUT: begin
        cmd.sel_done  = out_fire;
        cmd.res_taken = out_fire;
        cmd.sel_clr   = out_fire;
      end
      default: cmd = '0;
    endcase
    cmd.sqrt_init = (state_r == ST_ACC_END);
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_OUT);

endmodule

### hw/rtl/knn_datapath.sv
// ----------------------------------------------------------------------------
// knn_datapath
// feature store, squared difference accumulator, bit serial root and selector
// ----------------------------------------------------------------------------
module knn_datapath import knn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_we,
  input  logic [SubjW-1:0]  in_subject,
  input  logic [FeatW-1:0]  in_feature,
  input  logic [15:0]       in_value,
  input  logic [KW-1:0]     in_count,
  input  logic [CntW-1:0]   num_subjects,
  input  logic [CntW-1:0]   num_features,
  input  logic [DistW-1:0]  cutoff,
  input  knn_cmd_t          cmd,
  output knn_stat_t         stat,
  output logic [SubjW-1:0]  res_neighbour,
  output logic [DistW-1:0]  res_distance,
  output logic              res_found,
  output logic              res_last
);

  logic [15:0] store_q [MaxSubjects*MaxFeatures];
  logic [DistW-1:0] dist_mem [MaxSubjects];

  logic [SubjW-1:0] node_r;
  logic [KW-1:0]    k_r;
  logic [KW-1:0]    r_r, r_nxt;
  logic [CntW-1:0]  ns_r, nf_r;
  logic [CntW-1:0]  subj_r;
  logic [CntW-1:0]  feat_r;
  logic [15:0]      rd_a_r, rd_b_r;
  logic [SumW-1:0]  sum_r;
  logic [MaxSubjects-1:0] marks_r;
  logic [SumW-1:0]  rem_r;
  logic [RootW-1:0] root_r;
  logic [4:0]       step_r;
  logic             best_found_r;
  logic [SubjW-1:0] best_r;
  logic [DistW-1:0] bestd_r;
  logic [DistW-1:0] cand_d_r;
  logic             cand_ok_r;
  logic [SubjW-1:0] cand_i_r;

  // store write and paired read of query row and candidate row
  always_ff @(posedge clk) begin
    if (load_we) store_q[{in_subject, in_feature}] <= in_value;
  end

  logic [AddrW-1:0] addr_a, addr_b;
  assign addr_a = {node_r, feat_r[FeatW-1:0]};
  assign addr_b = {subj_r[SubjW-1:0], feat_r[FeatW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.acc_rd) begin
      rd_a_r <= store_q[addr_a];
      rd_b_r <= store_q[addr_b];
    end
  end

  // query parameters and counters
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      node_r <= in_subject;
      k_r    <= (in_count > KW'(MaxNeighbours)) ? KW'(MaxNeighbours) : in_count;
      ns_r   <= (num_subjects > CntW'(MaxSubjects)) ? CntW'(MaxSubjects) : num_subjects;
      nf_r   <= (num_features > CntW'(MaxFeatures)) ? CntW'(MaxFeatures) : num_features;
      r_r    <= '0;
    end else if (cmd.res_taken) begin
      r_r <= r_r + 1'b1;
    end
  end
  assign r_nxt = r_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.sel_clr)  subj_r <= '0;
    else if (cmd.subj_inc)         subj_r <= subj_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.feat_clr)     feat_r <= '0;
    else if (cmd.acc_rd)  feat_r <= feat_r + 1'b1;
  end

  // squared difference accumulate, one feature per cycle
  // the magnitude of a difference fits 16 bits, so a 16 x 16 product serves
  logic signed [16:0] diff;
  logic [15:0]        mag;
  logic [SqW-1:0]     sq;
  logic               add_ok;
  assign diff = $signed({rd_a_r[15], rd_a_r}) - $signed({rd_b_r[15], rd_b_r});
  assign mag  = diff[16] ? 16'(-diff) : diff[15:0];
  assign sq   = {16'd0, mag} * {16'd0, mag};
  // the read issued for feature index f is valid while f < nf
  logic [CntW-1:0] feat_prev_r;
  always_ff @(posedge clk) begin
    if (cmd.acc_rd) feat_prev_r <= feat_r;
  end
  assign add_ok = feat_prev_r < nf_r;

  always_ff @(posedge clk) begin
    if (cmd.feat_clr)                sum_r <= '0;
    else if (cmd.acc_add && add_ok)  sum_r <= sum_r + SumW'(sq);
  end
  assign stat.feat_last = (feat_r >= nf_r) || (feat_r == CntW'(MaxFeatures - 1));

  // restoring square root, two bits of radicand per step
  logic [SumW-1:0]  rem_sh;
  assign rem_sh = rem_r;
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rem_r  <= '0;
      root_r <= '0;
      step_r <= '0;
    end else if (cmd.sqrt_step) begin
      if ({rem_sh[SumW-3:0], sum_r[SumW-1 - 2*step_r -: 2]} >= {root_r, 2'b01}) begin
        rem_r  <= {rem_sh[SumW-3:0], sum_r[SumW-1 - 2*step_r -: 2]}
                  - SumW'({root_r, 2'b01});
        root_r <= {root_r[RootW-2:0], 1'b1};
      end else begin
        rem_r  <= {rem_sh[SumW-3:0], sum_r[SumW-1 - 2*step_r -: 2]};
        root_r <= {root_r[RootW-2:0], 1'b0};
      end
      step_r <= step_r + 1'b1;
    end
  end
  assign stat.sqrt_last = (step_r == 5'(RootW - 1));

  // distance table, one entry per subject
  always_ff @(posedge clk) begin
    if (cmd.dist_wr) dist_mem[subj_r[SubjW-1:0]] <= root_r;
  end

  assign stat.subj_last = (subj_r + 1'b1 >= ns_r) || (subj_r == CntW'(MaxSubjects - 1));

  // registered read of candidate distance, then compare
  always_ff @(posedge clk) begin
    cand_d_r  <= dist_mem[subj_r[SubjW-1:0]];
    cand_i_r  <= subj_r[SubjW-1:0];
    cand_ok_r <= cmd.sel_step && (subj_r < ns_r);
  end

  logic cand_hit;
  assign cand_hit = cand_ok_r && (cand_i_r != node_r) && !marks_r[cand_i_r]
                    && (cand_d_r < cutoff)
                    && (!best_found_r || cand_d_r < bestd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (cmd.sel_clr) begin
      best_found_r <= 1'b0;
    end else if (cand_hit) begin
      best_found_r <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cand_hit) begin
      best_r  <= cand_i_r;
      bestd_r <= cand_d_r;
    end
  end

  // picked marks
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start)             marks_r <= '0;
    else if (cmd.sel_done && best_found_r) marks_r[best_r] <= 1'b1;
  end

  // result
  assign res_found     = best_found_r;
  assign res_neighbour = best_found_r ? best_r : '0;
  assign res_distance  = best_found_r ? bestd_r : '0;
  assign res_last      = (r_nxt == k_r);
  assign stat.res_last = res_last;

endmodule
